// File: src/cdda_pkg.sv
// cdda_pkg: command codes, calendar constants and month-length helpers
// shared by the front, back and top of the calendar date day adder
// no dependencies
`default_nettype none

package cdda_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int YMOD_BITS  = 9;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_BITS-1:0]   DAY_FIRST = 5'd1;

  // ceil(2^33 / 25), exact quotient by 25 for any 28-bit dividend
  localparam logic [28:0]           RECIP_25   = 29'd343597384;
  localparam logic [YMOD_BITS-1:0]  YMOD_LAST  = 9'd399;
  localparam logic [YMOD_BITS-1:0]  CENT_1     = 9'd100;
  localparam logic [YMOD_BITS-1:0]  CENT_2     = 9'd200;
  localparam logic [YMOD_BITS-1:0]  CENT_3     = 9'd300;

  localparam int                    RESET_YEAR = 1970;
  localparam logic [YMOD_BITS-1:0]  RESET_YMOD = 9'd370;

  // leap test on the year taken modulo 400
  function automatic logic is_leap(input logic [YMOD_BITS-1:0] ymod);
    is_leap = (ymod[1:0] == 2'b00) && (ymod != CENT_1) && (ymod != CENT_2)
              && (ymod != CENT_3);
  endfunction

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    unique case (m)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/cdda_front.sv
// cdda_front: input stage, takes a transfer, masks the fields to the
// configured widths and clamps month and lower day bound
// depends on cdda_pkg
`default_nettype none

module cdda_front import cdda_pkg::*; #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  cmd,
  input  wire logic [15:0]           day_count,
  input  wire logic [15:0]           new_year,
  input  wire logic [3:0]            new_month,
  input  wire logic [4:0]            new_day,
  output logic                       f_valid,
  input  wire logic                  f_ready,
  output logic                       f_cmd,
  output logic [COUNT_BITS-1:0]      f_count,
  output logic [YEAR_BITS-1:0]       f_year,
  output logic [MONTH_BITS-1:0]      f_month,
  output logic [DAY_BITS-1:0]        f_day
);

  logic [47:0]            year_ext;
  logic [47:0]            count_ext;
  logic [MONTH_BITS-1:0]  month_clamped;
  logic [DAY_BITS-1:0]    day_clamped;

  assign year_ext  = {32'd0, new_year};
  assign count_ext = {32'd0, day_count};

  always_comb begin
    priority if (new_month == 4'd0) begin
      month_clamped = MONTH_JAN;
    end else if (new_month > MONTH_DEC) begin
      month_clamped = MONTH_DEC;
    end else begin
      month_clamped = new_month;
    end
  end

  assign day_clamped = (new_day == 5'd0) ? DAY_FIRST : new_day;

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd   <= cmd;
      f_count <= (cmd == CMD_ADD) ? count_ext[COUNT_BITS-1:0] : '0;
      f_year  <= year_ext[YEAR_BITS-1:0];
      f_month <= month_clamped;
      f_day   <= day_clamped;
    end
  end

endmodule

`default_nettype wire

// File: src/cdda_queue.sv
// cdda_queue: two-entry queue between the front and the back
// no dependencies
`default_nettype none

module cdda_queue #(
  parameter int WIDTH = 42
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [WIDTH-1:0]  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [WIDTH-1:0]       pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/cdda_back.sv
// cdda_back: date state, year modulo 400 by reciprocal multiplication on
// load, month walk on add, and the output register
// depends on cdda_pkg
`default_nettype none

module cdda_back import cdda_pkg::*; #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire logic                  q_cmd,
  input  wire logic [COUNT_BITS-1:0] q_count,
  input  wire logic [YEAR_BITS-1:0]  q_year,
  input  wire logic [MONTH_BITS-1:0] q_month,
  input  wire logic [DAY_BITS-1:0]   q_day,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                cur_year,
  output logic [3:0]                 cur_month,
  output logic [4:0]                 cur_day,
  output logic                       year_wrapped
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]            state;
  logic [YEAR_BITS-1:0]  year;
  logic [YMOD_BITS-1:0]  ymod;
  logic [MONTH_BITS-1:0] month;
  logic [DAY_BITS-1:0]   day;
  logic [COUNT_BITS-1:0] left;
  logic                  wrapped;
  logic [23:0]           quot;

  logic [31:0]           year32;
  logic [56:0]           prod;
  logic [32:0]           quot_x400;
  logic [32:0]           rem_full;
  logic [DAY_BITS-1:0]   len;
  logic [COUNT_BITS:0]   sum;
  logic                  fits;
  logic [DAY_BITS-1:0]   step;
  logic [YEAR_BITS+15:0] year_wide;
  logic                  out_free;

  assign len = month_len(month, is_leap(ymod));

  // year / 400 taken as (year / 16) / 25 by reciprocal multiplication
  assign year32    = 32'(year);
  assign prod      = {29'd0, year32[31:4]} * {28'd0, RECIP_25};
  assign quot_x400 = {1'b0, quot, 8'd0} + {2'd0, quot, 7'd0} + {5'd0, quot, 4'd0};
  assign rem_full  = {1'b0, year32} - quot_x400;

  assign sum       = {{(COUNT_BITS + 1 - DAY_BITS){1'b0}}, day} + {1'b0, left};
  assign fits      = sum <= {{(COUNT_BITS + 1 - DAY_BITS){1'b0}}, len};
  assign step      = len - day + DAY_FIRST;
  assign year_wide = {16'd0, year};
  assign out_free  = !out_valid || out_ready;
  assign q_ready   = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      year    <= YEAR_BITS'(RESET_YEAR);
      ymod    <= RESET_YMOD;
      month   <= MONTH_JAN;
      day     <= DAY_FIRST;
      wrapped <= 1'b0;
      left    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            wrapped <= 1'b0;
            if (q_cmd == CMD_LOAD) begin
              year  <= q_year;
              ymod  <= '0;
              month <= q_month;
              day   <= q_day;
              state <= ST_DIV;
            end else begin
              left  <= q_count;
              state <= ST_WALK;
            end
          end
        end
        ST_DIV: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          ymod  <= rem_full[YMOD_BITS-1:0];
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (day > len) begin
            day <= len;
          end
          state <= ST_DONE;
        end
        ST_WALK: begin
          if (fits) begin
            day   <= sum[DAY_BITS-1:0];
            state <= ST_DONE;
          end else begin
            left <= left - {{(COUNT_BITS - DAY_BITS){1'b0}}, step};
            day  <= DAY_FIRST;
            if (month == MONTH_DEC) begin
              month <= MONTH_JAN;
              if (year == {YEAR_BITS{1'b1}}) begin
                year    <= '0;
                ymod    <= '0;
                wrapped <= 1'b1;
              end else begin
                year <= year + 1'b1;
                ymod <= (ymod == YMOD_LAST) ? '0 : ymod + 1'b1;
              end
            end else begin
              month <= month + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      quot <= prod[56:33];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      cur_year     <= year_wide[15:0];
      cur_month    <= month;
      cur_day      <= day;
      year_wrapped <= wrapped;
    end
  end

  // stored date stays a legal calendar date outside a load in progress
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_WALK || state == ST_DONE)
      |-> (month >= MONTH_JAN && month <= MONTH_DEC && day >= DAY_FIRST && day <= len))
    else $error("stored date out of range");

  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    ymod <= YMOD_LAST)
    else $error("year modulo 400 out of range");

  a_walk_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !fits) |=> (left < $past(left)))
    else $error("month walk made no progress");

  a_load_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> !wrapped)
    else $error("wrap flag set on a load");

endmodule

`default_nettype wire

// File: src/calendar_date_day_adder_unit.sv
// calendar_date_day_adder_unit: top level, front stage, queue and back
// depends on cdda_pkg, cdda_front, cdda_queue, cdda_back
//
//   channel  handshake              payload
//   in       in_valid / in_ready    cmd, day_count, new_year, new_month, new_day
//   out      out_valid / out_ready  cur_year, cur_month, cur_day, year_wrapped
//
// an add goes from IDLE into the month walk in the back, which crosses one month
//   per step in WALK, then through DONE to the output register
// a load goes through the DIV and MOD states of the back, which take the year
//   modulo 400, and FIX, which clamps the day, then DONE and the output register
// reset gives 1970-01-01 and empties queue and output register
// a stalled output holds the back; the front and queue keep taking up to
//   three further items
`default_nettype none

module calendar_date_day_adder_unit import cdda_pkg::*; #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [15:0] day_count,
  input  wire logic [15:0] new_year,
  input  wire logic [3:0]  new_month,
  input  wire logic [4:0]  new_day,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      cur_year,
  output logic [3:0]       cur_month,
  output logic [4:0]       cur_day,
  output logic             year_wrapped
);

  localparam int Q_WIDTH = 1 + COUNT_BITS + YEAR_BITS + MONTH_BITS + DAY_BITS;

  logic                  f_valid;
  logic                  f_ready;
  logic                  f_cmd;
  logic [COUNT_BITS-1:0] f_count;
  logic [YEAR_BITS-1:0]  f_year;
  logic [MONTH_BITS-1:0] f_month;
  logic [DAY_BITS-1:0]   f_day;

  logic                  q_valid;
  logic                  q_ready;
  logic [Q_WIDTH-1:0]    q_data;
  logic                  q_cmd;
  logic [COUNT_BITS-1:0] q_count;
  logic [YEAR_BITS-1:0]  q_year;
  logic [MONTH_BITS-1:0] q_month;
  logic [DAY_BITS-1:0]   q_day;

  cdda_front #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .day_count (day_count),
    .new_year  (new_year),
    .new_month (new_month),
    .new_day   (new_day),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_cmd     (f_cmd),
    .f_count   (f_count),
    .f_year    (f_year),
    .f_month   (f_month),
    .f_day     (f_day)
  );

  cdda_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_cmd, f_count, f_year, f_month, f_day}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign {q_cmd, q_count, q_year, q_month, q_day} = q_data;

  cdda_back #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .q_count      (q_count),
    .q_year       (q_year),
    .q_month      (q_month),
    .q_day        (q_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cur_year     (cur_year),
    .cur_month    (cur_month),
    .cur_day      (cur_day),
    .year_wrapped (year_wrapped)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for calendar_date_day_adder_unit: loads and day additions with
// a date predictor, result checking in order, random idling and backpressure
// depends on cdda_pkg and the calendar_date_day_adder_unit rtl
module testbench;
  import cdda_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        wrapped;
  } date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_ADD;
  logic [15:0] day_count = '0;
  logic [15:0] new_year = '0;
  logic [3:0]  new_month = '0;
  logic [4:0]  new_day = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        year_wrapped;

  calendar_date_day_adder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .day_count    (day_count),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cur_year     (cur_year),
    .cur_month    (cur_month),
    .cur_day      (cur_day),
    .year_wrapped (year_wrapped)
  );

  always #5 clk = ~clk;

  // predictor state, a copy of the date the block should hold
  logic [15:0] held_year  = 16'(RESET_YEAR);
  logic [3:0]  held_month = MONTH_JAN;
  logic [4:0]  held_day   = DAY_FIRST;

  date_t pending_dates[$];
  int    errors = 0;
  int    loads_done = 0;
  int    adds_done = 0;
  int    wraps_done = 0;
  int    results_seen = 0;
  int    cycle_count = 0;
  bit    quiet = 1'b0;
  int    hold_asks = 0;
  int    hold_served = 0;
  int    hold_left = 0;

  function automatic int days_of(logic [15:0] y, int m);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == MONTH_FEB) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic void predict_date(logic op, logic [15:0] cnt, logic [15:0] yr,
                                       logic [3:0] mo, logic [4:0] dy);
    date_t res;
    int left, len, m, d;
    bit done;
    res.wrapped = 1'b0;
    if (op == CMD_LOAD) begin
      m = mo;
      d = dy;
      if (m < 1) m = 1;
      if (m > MONTH_DEC) m = MONTH_DEC;
      len = days_of(yr, m);
      if (d < 1) d = 1;
      if (d > len) d = len;
      held_year  = yr;
      held_month = 4'(m);
      held_day   = 5'(d);
      loads_done++;
    end else begin
      left = cnt;
      done = 1'b0;
      while (!done) begin
        len = days_of(held_year, held_month);
        if (held_day + left <= len) begin
          held_day = 5'(held_day + left);
          done = 1'b1;
        end else begin
          left -= len - held_day + 1;
          held_day = DAY_FIRST;
          if (held_month == MONTH_DEC) begin
            held_month = MONTH_JAN;
            if (held_year == 16'hFFFF) begin
              held_year = '0;
              res.wrapped = 1'b1;
            end else begin
              held_year = held_year + 16'd1;
            end
          end else begin
            held_month = held_month + 4'd1;
          end
        end
      end
      adds_done++;
      if (res.wrapped) wraps_done++;
    end
    res.year  = held_year;
    res.month = held_month;
    res.day   = held_day;
    pending_dates.push_back(res);
  endfunction

  // one transfer on the input channel, then maybe a random gap
  task automatic send_item(logic op, logic [15:0] cnt, logic [15:0] yr,
                           logic [3:0] mo, logic [4:0] dy);
    in_valid  <= 1'b1;
    cmd       <= op;
    day_count <= cnt;
    new_year  <= yr;
    new_month <= mo;
    new_day   <= dy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_date(op, cnt, yr, mo, dy);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic add_days(logic [15:0] cnt);
    send_item(CMD_ADD, cnt, 16'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic load_date(logic [15:0] yr, logic [3:0] mo, logic [4:0] dy);
    send_item(CMD_LOAD, 16'($urandom), yr, mo, dy);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_add_basics();
    add_days(16'd0);
    add_days(16'd30);
    add_days(16'd1);
    add_days(16'd28);
    load_date(16'd2000, MONTH_FEB, 5'd28);
    add_days(16'd1);
    add_days(16'd1);
    load_date(16'd1900, MONTH_FEB, 5'd28);
    add_days(16'd1);
    // year rolls over to zero, and year zero is a leap year
    load_date(16'hFFFF, MONTH_DEC, 5'd31);
    add_days(16'd1);
    add_days(16'd59);
    add_days(16'hFFFF);
    load_date(16'd65400, MONTH_JAN, DAY_FIRST);
    add_days(16'hFFFF);
  endtask

  task automatic test_load_clamps();
    load_date(16'd2024, MONTH_FEB, 5'd31);
    load_date(16'd1900, MONTH_FEB, 5'd29);
    load_date(16'd2000, MONTH_FEB, 5'd30);
    load_date(16'd0, MONTH_FEB, 5'd31);
    load_date(16'd2023, 4'd4, 5'd31);
    load_date(16'd1999, 4'd0, 5'd0);
    load_date(16'd2001, 4'd15, 5'd31);
    load_date(16'hFFFF, 4'd13, 5'd0);
    load_date(16'd2022, 4'd6, 5'd15);
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    hold_asks++;
    for (i = 0; i < 12; i++) begin
      if (i % 4 == 0) load_date(16'($urandom_range(2400, 1600)), 4'($urandom_range(12, 1)),
                                5'($urandom_range(31, 1)));
      else add_days(16'($urandom_range(40)));
    end
    pause_until_drained();
  endtask

  task automatic test_random_dates(int n);
    int i, sel;
    logic [15:0] cnt, yr;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        sel = $urandom_range(9);
        if (sel < 2) yr = 16'hFFFF - 16'($urandom_range(40));
        else if (sel < 6) yr = 16'($urandom_range(2400, 1600));
        else yr = 16'($urandom);
        load_date(yr, 4'($urandom), 5'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) cnt = 16'($urandom_range(62));
        else if (sel < 90) cnt = 16'($urandom_range(1500, 63));
        else if (sel < 98) cnt = 16'($urandom_range(20000, 1501));
        else cnt = 16'hFFFF;
        add_days(cnt);
      end
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    date_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d-%0d-%0d", $time,
                 cur_year, cur_month, cur_day);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        check_field("cur_year", want.year, cur_year);
        check_field("cur_month", want.month, cur_month);
        check_field("cur_day", want.day, cur_day);
        check_field("year_wrapped", want.wrapped, year_wrapped);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_dates.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_add_basics();
    test_load_clamps();
    pause_until_drained();
    test_backpressure();
    test_random_dates(200);
    quiet = 1'b1;
    test_random_dates(40);
    quiet = 1'b0;
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d dates: %0d loads with clamping, %0d additions (%0d rolling the year",
             results_seen, loads_done, adds_done, wraps_done);
    $display("over zero), with random idling, a quiet stretch and a long output stall");
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/cdda_pkg.sv
src/cdda_front.sv
src/cdda_queue.sv
src/cdda_back.sv
src/calendar_date_day_adder_unit.sv
tb/testbench.sv
